/* sv/hamming_near_pair_join_macros.svh */
// Assertion macros shared by the near pair join RTL.
`ifndef HAMMING_NEAR_PAIR_JOIN_MACROS_SVH
`define HAMMING_NEAR_PAIR_JOIN_MACROS_SVH

// same-cycle implication
`define HNPJ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HNPJ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/hnpj_pkg.sv */
// Types, constants and helper functions for the near pair join block.
`timescale 1ns / 1ps
package hnpj_pkg;

   localparam int MaxEntries    = 32;
   localparam int SketchBits    = 64;
   localparam int SketchFieldW  = 64;
   localparam int IdW           = 32;
   localparam int BucketSizeW   = 16;
   localparam int LimitW        = 7;
   localparam int AddrW         = $clog2(MaxEntries);
   localparam int CntW          = $clog2(MaxEntries + 1);
   localparam int NumBytes      = SketchFieldW / 8;
   localparam int ByteCntW      = 4;
   localparam logic [LimitW-1:0] LimitReset = LimitW'(4);
   localparam logic [SketchFieldW-1:0] SketchMask =
      {SketchFieldW{1'b1}} >> (SketchFieldW - SketchBits);

   typedef struct packed {
      logic [SketchFieldW-1:0] sketch;
      logic [IdW-1:0]          image_id;
      logic                    first_of_bucket;
      logic [BucketSizeW-1:0]  bucket_size;
   } req_type;

   typedef struct packed {
      logic [IdW-1:0] from_id;
      logic [IdW-1:0] to_id;
      logic           last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [SketchFieldW-1:0] sketch;
      logic [IdW-1:0]          image_id;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [AddrW-1:0] addr;
      entry_type        entry;
   } store_wr_type;

   typedef struct packed {
      logic             en;
      logic [AddrW-1:0] addr;
   } store_rd_type;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SCAN    = 5'b00010,
      ST_HOLD    = 5'b00100,
      ST_FLUSH_A = 5'b01000,
      ST_FLUSH_B = 5'b10000
   } state_type;

   function automatic logic [ByteCntW-1:0] byte_count(input logic [7:0] b);
      logic [ByteCntW-1:0] n;
      n = '0;
      for (int k = 0; k < 8; k++) begin
         n = n + ByteCntW'(b[k]);
      end
      return n;
   endfunction

endpackage

/* sv/hnpj_store.sv */
// Entry store: sketch and id memory with one write port and one registered read port.
`timescale 1ns / 1ps
module hnpj_store (
   input  logic                  clock,
   input  hnpj_pkg::store_wr_type wr,
   input  hnpj_pkg::store_rd_type rd,
   output hnpj_pkg::entry_type    rd_data
);
   import hnpj_pkg::*;

   entry_type mem [MaxEntries];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/hamming_near_pair_join.sv */
// Top level of the near pair join: sequencer, distance unit and result mux.
`timescale 1ns / 1ps
`include "hamming_near_pair_join_macros.svh"
//
// Entries of one hash bucket arrive on req_data, taken when start is high and
// busy is low. Each entry is checked against every earlier entry of the bucket,
// one stored entry per cycle when not stalled, via one XOR/popcount/compare unit fed
// from a registered-read entry memory. A pair with differing ids and distance
// below the csr limit gives two results on rsp_data, (new, old) then (old, new),
// each strobed by rsp_valid for one cycle; last_of_run marks the final one.
// The receiver cannot stall; a matching pair is held until the next match or
// the end of the scan. The rate is set by the single memory read port and the
// one distance unit, one stored entry per cycle; the scan stalls while the first
// result of a held pair goes out. An entry of an oversized bucket leaves busy
// low and gives no result.
// csr_we writes the distance limit; write it only while busy is low.
// Reset clears the entry count, the oversized flag and the sequencer, and sets
// the limit to 4; stored entries are not cleared.
//
module hamming_near_pair_join (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  hnpj_pkg::req_type         req_data,
   output logic                      rsp_valid,
   output hnpj_pkg::rsp_type         rsp_data,
   input  logic                      csr_we,
   input  logic [hnpj_pkg::LimitW-1:0] csr_wdata
);
   import hnpj_pkg::*;

   state_type               state_ff, state_in;
   logic [CntW-1:0]         cnt_ff, cnt_in;
   logic                    big_ff, big_in;
   logic [LimitW-1:0]       limit_ff;
   logic [SketchFieldW-1:0] cur_sketch_ff, cur_sketch_in;
   logic [IdW-1:0]          cur_id_ff, cur_id_in;
   logic [AddrW-1:0]        idx_ff, idx_in;
   logic [AddrW-1:0]        last_idx_ff, last_idx_in;
   logic                    iss_ff, iss_in;
   logic                    v1_ff, v1_in;
   logic                    v2_ff, v2_in;
   logic [ByteCntW-1:0]     byte_cnt_ff [NumBytes];
   logic [ByteCntW-1:0]     byte_cnt_in [NumBytes];
   logic                    ne_ff, ne_in;
   logic [IdW-1:0]          old_id_ff, old_id_in;
   logic                    pend_ff, pend_in;
   logic [IdW-1:0]          pend_id_ff, pend_id_in;

   logic                    accept;
   logic                    adv;
   logic                    match;
   logic                    empty;
   logic [LimitW-1:0]       ham_dist;
   logic [CntW-1:0]         cnt_eff;
   logic                    big_eff;
   logic [SketchFieldW-1:0] diff;
   store_wr_type            st_wr;
   store_rd_type            st_rd;
   entry_type               st_data;

   hnpj_store u_store (
      .clock   (clock),
      .wr      (st_wr),
      .rd      (st_rd),
      .rd_data (st_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign empty  = !iss_ff && !v1_ff && !v2_ff;
   assign match  = v2_ff && ne_ff && (ham_dist < limit_ff);
   assign adv    = ((state_ff == ST_SCAN) && !(match && pend_ff)) || (state_ff == ST_HOLD);
   assign diff   = (st_data.sketch ^ cur_sketch_ff) & SketchMask;

   always_comb begin
      ham_dist = '0;
      for (int b = 0; b < NumBytes; b++) begin
         ham_dist = ham_dist + LimitW'(byte_cnt_ff[b]);
      end
   end

   always_comb begin
      cnt_eff = req_data.first_of_bucket ? '0 : cnt_ff;
      big_eff = req_data.first_of_bucket ?
                (req_data.bucket_size > BucketSizeW'(MaxEntries)) : big_ff;
   end

   always_comb begin
      st_wr.en           = 1'b0;
      st_wr.addr         = cnt_eff[AddrW-1:0];
      st_wr.entry.sketch = req_data.sketch & SketchMask;
      st_wr.entry.image_id = req_data.image_id;
      st_rd.en           = adv && iss_ff;
      st_rd.addr         = idx_ff;

      state_in      = state_ff;
      cnt_in        = cnt_ff;
      big_in        = big_ff;
      cur_sketch_in = cur_sketch_ff;
      cur_id_in     = cur_id_ff;
      idx_in        = idx_ff;
      last_idx_in   = last_idx_ff;
      iss_in        = iss_ff;
      v1_in         = v1_ff;
      v2_in         = v2_ff;
      byte_cnt_in   = byte_cnt_ff;
      ne_in         = ne_ff;
      old_id_in     = old_id_ff;
      pend_in       = pend_ff;
      pend_id_in    = pend_id_ff;

      rsp_valid            = 1'b0;
      rsp_data.from_id     = cur_id_ff;
      rsp_data.to_id       = pend_id_ff;
      rsp_data.last_of_run = 1'b0;

      // advance the scan pipeline
      if (adv) begin
         v1_in = iss_ff;
         if (iss_ff) begin
            idx_in = idx_ff + 1'b1;
            iss_in = (idx_ff != last_idx_ff);
         end
         v2_in     = v1_ff;
         ne_in     = (st_data.image_id != cur_id_ff);
         old_id_in = st_data.image_id;
         for (int b = 0; b < NumBytes; b++) begin
            byte_cnt_in[b] = byte_count(diff[b*8 +: 8]);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in = cnt_eff;
               big_in = big_eff;
               if (!big_eff) begin
                  if (cnt_eff == CntW'(MaxEntries)) begin
                     big_in = 1'b1;
                  end else begin
                     st_wr.en      = 1'b1;
                     cnt_in        = cnt_eff + 1'b1;
                     cur_sketch_in = req_data.sketch & SketchMask;
                     cur_id_in     = req_data.image_id;
                     idx_in        = '0;
                     last_idx_in   = cnt_eff[AddrW-1:0] - 1'b1;
                     iss_in        = (cnt_eff != '0);
                     v1_in         = 1'b0;
                     v2_in         = 1'b0;
                     pend_in       = 1'b0;
                     state_in      = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (match && pend_ff) begin
               rsp_valid = 1'b1;
               state_in  = ST_HOLD;
            end else begin
               if (match) begin
                  pend_in    = 1'b1;
                  pend_id_in = old_id_ff;
               end
               if (empty) begin
                  state_in = pend_ff ? ST_FLUSH_A : ST_IDLE;
               end
            end
         end
         ST_HOLD: begin
            rsp_valid        = 1'b1;
            rsp_data.from_id = pend_id_ff;
            rsp_data.to_id   = cur_id_ff;
            pend_id_in       = old_id_ff;
            state_in         = ST_SCAN;
         end
         ST_FLUSH_A: begin
            rsp_valid = 1'b1;
            state_in  = ST_FLUSH_B;
         end
         ST_FLUSH_B: begin
            rsp_valid            = 1'b1;
            rsp_data.from_id     = pend_id_ff;
            rsp_data.to_id       = cur_id_ff;
            rsp_data.last_of_run = 1'b1;
            pend_in              = 1'b0;
            state_in             = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         big_ff   <= 1'b0;
         iss_ff   <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         big_ff   <= big_in;
         iss_ff   <= iss_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LimitReset;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      cur_sketch_ff <= cur_sketch_in;
      cur_id_ff     <= cur_id_in;
      idx_ff        <= idx_in;
      last_idx_ff   <= last_idx_in;
      byte_cnt_ff   <= byte_cnt_in;
      ne_ff         <= ne_in;
      old_id_ff     <= old_id_in;
      pend_id_ff    <= pend_id_in;
   end

   `HNPJ_ASSERT_NOW(a_rsp_only_busy, clock, reset, rsp_valid, busy, "result while idle")
   `HNPJ_ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_valid && rsp_data.last_of_run, !busy, "busy")
   `HNPJ_ASSERT_NOW(a_mid_needs_pend, clock, reset, rsp_valid && !rsp_data.last_of_run, pend_ff, "no pair")
   `HNPJ_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CntW'(MaxEntries), "count overflow")
   `HNPJ_ASSERT_NEXT(a_big_no_run, clock, reset, accept && big_eff, !busy, "oversized run")

endmodule
